>>> rtl/message_frame_checker_defines.svh
// ----------------------------------------------------------------------------
// message_frame_checker_defines
// Assertion macros for the frame checker RTL (used by mfc_fifo). They sample on clk_i and
// are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_FRAME_CHECKER_DEFINES_SVH
`define MESSAGE_FRAME_CHECKER_DEFINES_SVH

`ifndef SYNTH

// Property that must hold at every clock edge out of reset
`define MFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mfc assertion failed");

// Condition in one cycle implies a consequence in the next one
`define MFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mfc assertion failed");

`else

`define MFC_ASSERT(lbl, prop)
`define MFC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> rtl/mfc_pkg.sv
// ----------------------------------------------------------------------------
// mfc_pkg
// Types, constants and the CRC-32 byte step for the message frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mfc_pkg;

  localparam logic [31:0] CrcPoly          = 32'hEDB88320;
  localparam logic [31:0] CrcOnes          = 32'hFFFFFFFF;
  localparam logic [7:0]  VersionReset     = 8'h01;
  localparam int unsigned FifoDepthDefault = 4;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SHORT   = 2'd2,
    ST_CRC     = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } mfc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  message_type;
    logic [31:0] payload_length;
    logic [31:0] computed_crc;
  } mfc_out_t;

  // One classified byte, front to back
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        crc_en;      // byte belongs to the payload
    logic        last;
    status_e     pre_status;  // ST_OK means the CRC compare still decides
    logic [7:0]  frame_type;
    logic [31:0] length;
    logic [31:0] exp_crc;
  } mfc_entry_t;

  // Reflected CRC-32, one byte, bitwise
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mfc_front.sv
// ----------------------------------------------------------------------------
// mfc_front
// Accepts message bytes, parses the 16-byte header and tags each byte as
// header, payload or trailing. Decides every status except the CRC compare.
// ----------------------------------------------------------------------------
`default_nettype none

module mfc_front import mfc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire mfc_in_t    in_data_i,
  input  wire logic [7:0] expected_version_i,
  input  wire logic       full_i,
  output logic            in_stall_o,
  output logic            push_o,
  output mfc_entry_t      entry_o
);

  localparam logic [4:0] PosType    = 5'd0;
  localparam logic [4:0] PosVersion = 5'd1;
  localparam logic [4:0] PosLenLo   = 5'd4;
  localparam logic [4:0] PosLenHi   = 5'd7;
  localparam logic [4:0] PosCrcLo   = 5'd8;
  localparam logic [4:0] PosCrcHi   = 5'd11;
  localparam logic [4:0] PosHdrLast = 5'd15;
  localparam logic [4:0] PosHdrDone = 5'd16;

  logic [4:0]  pos_q, pos_d;
  logic [31:0] rem_q, rem_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  version_q, version_d;
  logic [31:0] length_q, length_d;
  logic [31:0] exp_crc_q, exp_crc_d;

  logic        accept;
  logic        hdr_phase;
  logic [31:0] rem_after;
  status_e     pre_status;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;
  assign hdr_phase  = (pos_q != PosHdrDone);

  // payload bytes still owed once this byte is counted
  always_comb begin
    if (pos_q == PosHdrLast) begin
      rem_after = length_q;
    end else if (rem_q != 32'd0) begin
      rem_after = rem_q - 32'd1;
    end else begin
      rem_after = 32'd0;
    end
  end

  always_comb begin
    if (pos_q < PosHdrLast) begin
      pre_status = ST_INVALID;
    end else if (version_q != expected_version_i) begin
      pre_status = ST_INVALID;
    end else if (rem_after != 32'd0) begin
      pre_status = ST_SHORT;
    end else begin
      pre_status = ST_OK;
    end
  end

  always_comb begin
    pos_d     = pos_q;
    rem_d     = rem_q;
    type_d    = type_q;
    version_d = version_q;
    length_d  = length_q;
    exp_crc_d = exp_crc_q;
    if (accept) begin
      if (hdr_phase) begin
        if (pos_q == PosType) begin
          type_d = in_data_i.data_byte;
        end else if (pos_q == PosVersion) begin
          version_d = in_data_i.data_byte;
        end else if (pos_q >= PosLenLo && pos_q <= PosLenHi) begin
          length_d[{pos_q[1:0], 3'b000} +: 8] = in_data_i.data_byte;
        end else if (pos_q >= PosCrcLo && pos_q <= PosCrcHi) begin
          exp_crc_d[{pos_q[1:0], 3'b000} +: 8] = in_data_i.data_byte;
        end
      end
      if (in_data_i.last_byte) begin
        pos_d = PosType;
        rem_d = 32'd0;
      end else begin
        if (hdr_phase) begin
          pos_d = pos_q + 5'd1;
        end
        if (pos_q >= PosHdrLast) begin
          rem_d = rem_after;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosType;
      rem_q <= 32'd0;
    end else begin
      pos_q <= pos_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q    <= type_d;
    version_q <= version_d;
    length_q  <= length_d;
    exp_crc_q <= exp_crc_d;
  end

  always_comb begin
    entry_o.data_byte  = in_data_i.data_byte;
    entry_o.crc_en     = !hdr_phase && (rem_q != 32'd0);
    entry_o.last       = in_data_i.last_byte;
    entry_o.pre_status = pre_status;
    entry_o.frame_type = type_q;
    entry_o.length     = length_q;
    entry_o.exp_crc    = exp_crc_q;
  end

endmodule

`default_nettype wire

>>> rtl/mfc_fifo.sv
// ----------------------------------------------------------------------------
// mfc_fifo
// Short queue of classified bytes between the parser and the CRC stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "message_frame_checker_defines.svh"

module mfc_fifo import mfc_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire mfc_entry_t entry_i,
  input  wire logic       pop_i,
  output logic            full_o,
  output logic            valid_o,
  output mfc_entry_t      entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mfc_entry_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `MFC_ASSERT(a_no_overflow, !(push_i && full_o))
  `MFC_ASSERT(a_no_underflow, !(pop_i && !valid_o))
  `MFC_ASSERT(a_cnt_range, cnt_q <= CntW'(Depth))
  `MFC_ASSERT_NXT(a_cnt_hold, push_i == pop_i, $stable(cnt_q))

endmodule

`default_nettype wire

>>> rtl/mfc_back.sv
// ----------------------------------------------------------------------------
// mfc_back
// Runs the CRC over payload bytes and, on the last byte, builds the status
// transaction in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mfc_back import mfc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire mfc_entry_t entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output mfc_out_t        out_data_o
);

  logic [31:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  mfc_out_t    out_q, out_d;

  logic [31:0] crc_next;
  logic [31:0] crc_final;
  logic        slot_free;
  status_e     status;

  assign slot_free   = !out_valid_q || !out_stall_i;
  // non-final bytes never need the output slot
  assign pop_o       = valid_i && (!entry_i.last || slot_free);
  assign crc_next    = entry_i.crc_en ? crc_byte(crc_q, entry_i.data_byte) : crc_q;
  assign crc_final   = crc_next ^ CrcOnes;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    if (entry_i.pre_status != ST_OK) begin
      status = entry_i.pre_status;
    end else if (crc_final != entry_i.exp_crc) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    crc_d       = crc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (pop_o) begin
      crc_d = entry_i.last ? CrcOnes : crc_next;
      if (entry_i.last) begin
        out_valid_d          = 1'b1;
        out_d.status         = status;
        out_d.message_type   = (status == ST_OK) ? entry_i.frame_type : 8'd0;
        out_d.payload_length = (status == ST_OK) ? entry_i.length : 32'd0;
        out_d.computed_crc   = (status == ST_OK || status == ST_CRC) ? crc_final : 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcOnes;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

`default_nettype wire

>>> rtl/message_frame_checker.sv
// ----------------------------------------------------------------------------
// message_frame_checker
// Length-prefixed frame checker: 16-byte header, CRC-32 over the payload,
// one status transaction per message.
//
//   channel   dir  handshake                payload
//   in        in   in_valid_i / in_stall_o  mfc_in_t  (data_byte, last_byte)
//   out       out  out_valid_o / out_stall_i mfc_out_t (status, type, len, crc)
//   cfg       in   cfg_we_i                 cfg_wdata_i (expected version)
//
// One byte per cycle sustained while the queue is not full. The status is
// registered after the last byte is accepted: the byte enters the queue on
// acceptance, the CRC stage takes it from the queue head, and the status goes
// to the output register; the CRC stage's single byte-wide step sets the cycle time.
// Reset empties the queue, restarts header parsing, presets the CRC and sets
// the expected version to 1.
// in_stall_o rises only when the queue is full, which happens only while the
// output is stalled with a result waiting and further bytes keep coming.
// ----------------------------------------------------------------------------
`default_nettype none

module message_frame_checker import mfc_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire mfc_in_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output mfc_out_t        out_data_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);

  logic [7:0] exp_version_q;
  logic       push, pop, full, q_valid;
  mfc_entry_t push_entry, head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_version_q <= VersionReset;
    end else if (cfg_we_i) begin
      exp_version_q <= cfg_wdata_i;
    end
  end

  mfc_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_data_i          (in_data_i),
    .expected_version_i (exp_version_q),
    .full_i             (full),
    .in_stall_o         (in_stall_o),
    .push_o             (push),
    .entry_o            (push_entry)
  );

  mfc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  mfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for message_frame_checker. Frames are built byte by
// byte (good ones, bad CRC, wrong version, cut header or payload, long length
// fields, noise), pushed through the byte channel with random gaps, and every
// status transaction is checked against a byte-level frame parser kept in the
// bench. The expected version is swept over several values between phases.
// ----------------------------------------------------------------------------

module tb_top import mfc_pkg::*; ();

  localparam int unsigned HdrBytes   = 16;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned PhaseBytes = 320;
  localparam int unsigned PrintCap   = 30;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  mfc_in_t    in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  mfc_out_t   out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = '0;

  message_frame_checker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Byte-level frame parser state
  logic [32:0] rx_count  = '0;
  logic [31:0] crc_acc   = CrcOnes;
  logic [7:0]  hdr_type  = '0;
  logic [7:0]  hdr_ver   = '0;
  logic [31:0] hdr_len   = '0;
  logic [31:0] hdr_crc   = '0;
  logic [7:0]  exp_ver   = VersionReset;

  mfc_in_t     link_bytes_q[$];
  mfc_out_t    frame_verdict_q[$];

  int unsigned bytes_queued  = 0;
  int unsigned bytes_taken   = 0;
  int unsigned verdicts_seen = 0;
  int unsigned err_count     = 0;
  int unsigned cycles        = 0;
  int unsigned status_tally[4];
  int unsigned src_gap       = 0;
  int unsigned sink_hold     = 0;
  bit          src_steady    = 1'b0;
  bit          sink_steady   = 1'b0;
  logic [7:0]  mid_ver;

  function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  // Advance the parser by one accepted byte; a last byte yields one verdict
  task automatic parse_frame_byte(input mfc_in_t it);
    mfc_out_t   res;
    logic [31:0] fin;
    status_e    st;
    if (rx_count < HdrBytes) begin
      case (rx_count[3:0]) inside
        4'd0: begin
          hdr_type = it.data_byte;
        end
        4'd1: begin
          hdr_ver = it.data_byte;
        end
        [4'd4:4'd7]: begin
          hdr_len[8*rx_count[1:0] +: 8] = it.data_byte;
        end
        [4'd8:4'd11]: begin
          hdr_crc[8*rx_count[1:0] +: 8] = it.data_byte;
        end
        default: ;
      endcase
    end else if (rx_count - HdrBytes < {1'b0, hdr_len}) begin
      crc_acc = crc32_update(crc_acc, it.data_byte);
    end
    if (rx_count != {33{1'b1}}) begin
      rx_count++;
    end
    if (it.last_byte) begin
      fin = ~crc_acc;
      // version is judged before the length
      if (rx_count < HdrBytes) begin
        st = ST_INVALID;
      end else if (hdr_ver != exp_ver) begin
        st = ST_INVALID;
      end else if (rx_count - HdrBytes < {1'b0, hdr_len}) begin
        st = ST_SHORT;
      end else if (fin != hdr_crc) begin
        st = ST_CRC;
      end else begin
        st = ST_OK;
      end
      res        = '0;
      res.status = st;
      if (st == ST_OK) begin
        res.message_type   = hdr_type;
        res.payload_length = hdr_len;
      end
      if (st == ST_OK || st == ST_CRC) begin
        res.computed_crc = fin;
      end
      frame_verdict_q.insert(frame_verdict_q.size(), res);
      status_tally[st]++;
      rx_count = '0;
      crc_acc  = CrcOnes;
    end
  endtask

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= PrintCap) begin
      $display("ERROR @%0t: %s", $time, what);
    end
  endtask

  task automatic check_verdict(input mfc_out_t got);
    mfc_out_t want;
    verdicts_seen++;
    if (frame_verdict_q.size() == 0) begin
      report_mismatch($sformatf("status %0d arrived with nothing outstanding", got.status));
    end else begin
      want = frame_verdict_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.message_type !== want.message_type)
        report_mismatch($sformatf("type %02h, want %02h", got.message_type,
                                  want.message_type));
      if (got.payload_length !== want.payload_length)
        report_mismatch($sformatf("length %08h, want %08h", got.payload_length,
                                  want.payload_length));
      if (got.computed_crc !== want.computed_crc)
        report_mismatch($sformatf("crc %08h, want %08h", got.computed_crc,
                                  want.computed_crc));
    end
  endtask

  // Driver: one byte transaction at a time, random gap before each
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_frame_byte(in_data_i);
        bytes_taken++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid_i <= 1'b0;
        end else if (link_bytes_q.size() > 0) begin
          in_data_i  <= link_bytes_q.pop_front();
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 49) == 0) src_steady = !src_steady;
          src_gap = src_steady ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each status transaction, then stalls for a random count
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_verdict(out_data_o);
        if ($urandom_range(0, 49) == 0) sink_steady = !sink_steady;
        sink_hold = sink_steady ? 0 : $urandom_range(0, 4);
      end else if (sink_hold > 0) begin
        sink_hold--;
      end
      out_stall_i <= (sink_hold > 0);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycles,
               frame_verdict_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Build a frame and queue up to keep bytes of it (0 keeps all)
  task automatic queue_frame(input logic [7:0] ftype, input logic [7:0] ver,
                             input logic [31:0] len_field, input int unsigned plen,
                             input bit bad_crc, input int unsigned trail,
                             input int unsigned keep);
    logic [7:0]  pay[$];
    logic [7:0]  msg[$];
    logic [31:0] crc;
    logic [7:0]  b;
    mfc_in_t     it;
    int unsigned n;
    crc = CrcOnes;
    for (int i = 0; i < plen; i++) begin
      b = 8'($urandom_range(0, 255));
      pay.insert(pay.size(), b);
      if (i < len_field) crc = crc32_update(crc, b);
    end
    crc = ~crc;
    if (bad_crc) crc = crc ^ (32'h1 << $urandom_range(0, 31));
    msg.insert(msg.size(), ftype);
    msg.insert(msg.size(), ver);
    msg.insert(msg.size(), 8'($urandom_range(0, 255)));
    msg.insert(msg.size(), 8'($urandom_range(0, 255)));
    for (int i = 0; i < 4; i++) msg.insert(msg.size(), len_field[8*i +: 8]);
    for (int i = 0; i < 4; i++) msg.insert(msg.size(), crc[8*i +: 8]);
    for (int i = 0; i < 4; i++) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
    foreach (pay[i]) msg.insert(msg.size(), pay[i]);
    for (int i = 0; i < trail; i++) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
    n = (keep == 0 || keep > msg.size()) ? msg.size() : keep;
    for (int i = 0; i < n; i++) begin
      it.data_byte = msg[i];
      it.last_byte = (i == n - 1);
      link_bytes_q.insert(link_bytes_q.size(), it);
    end
    bytes_queued += n;
  endtask

  task automatic queue_noise(input int unsigned n);
    mfc_in_t it;
    for (int i = 0; i < n; i++) begin
      it.data_byte = 8'($urandom_range(0, 255));
      it.last_byte = (i == n - 1);
      link_bytes_q.insert(link_bytes_q.size(), it);
    end
    bytes_queued += n;
  endtask

  task automatic wait_idle();
    while (bytes_taken != bytes_queued || frame_verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_version(input logic [7:0] v);
    wait_idle();
    repeat (6) @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    exp_ver = v;
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned plen;
    bit          paused;
    start  = bytes_queued;
    paused = 1'b0;
    while (bytes_queued - start < budget) begin
      // hold the sender once per phase until the block has drained
      if (!paused && bytes_queued - start > budget / 2) begin
        wait_idle();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160) : $urandom_range(0, 40);
      if (pick < 55) begin
        queue_frame(8'($urandom_range(0, 255)), exp_ver, plen, plen, 1'b0,
                    ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0, 0);
      end else if (pick < 65) begin
        queue_frame(8'($urandom_range(0, 255)), exp_ver, plen, plen, 1'b1, 0, 0);
      end else if (pick < 73) begin
        queue_frame(8'($urandom_range(0, 255)), exp_ver ^ 8'($urandom_range(1, 255)),
                    plen, plen, 1'b0, 0, 0);
      end else if (pick < 80) begin
        if (plen == 0) plen = 1;
        queue_frame(8'($urandom_range(0, 255)), exp_ver, plen, plen, 1'b0, 0,
                    HdrBytes + $urandom_range(0, plen - 1));
      end else if (pick < 86) begin
        queue_frame(8'($urandom_range(0, 255)), exp_ver, plen, plen, 1'b0, 0,
                    $urandom_range(1, HdrBytes - 1));
      end else if (pick < 91) begin
        // length field far beyond what is sent
        queue_frame(8'($urandom_range(0, 255)), exp_ver, $urandom() | 32'h100,
                    $urandom_range(0, 20), 1'b0, 0, 0);
      end else begin
        queue_noise($urandom_range(1, 40));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames under the reset version
    queue_frame(8'h00, 8'h01, 32'd0, 0, 1'b0, 0, 1);          // one byte only
    queue_frame(8'hFF, 8'h01, 32'd0, 0, 1'b0, 0, 15);         // header cut by one
    queue_frame(8'hFF, 8'h01, 32'd0, 0, 1'b0, 0, 0);          // empty payload
    queue_frame(8'h00, 8'h01, 32'd1, 1, 1'b0, 0, 0);
    queue_frame(8'h12, 8'h02, 32'd4, 4, 1'b0, 0, 0);          // wrong version
    queue_frame(8'h34, 8'h01, 32'd8, 8, 1'b0, 0, 19);         // payload cut
    queue_frame(8'h45, 8'h01, 32'd2, 2, 1'b0, 0, 16);         // header only
    queue_frame(8'h56, 8'h01, 32'hFFFF_FFFF, 2, 1'b0, 0, 0);
    queue_frame(8'h78, 8'h01, 32'd5, 5, 1'b1, 0, 0);          // crc off
    queue_frame(8'h9A, 8'h01, 32'd3, 3, 1'b0, 4, 0);          // trailing bytes
    queue_frame(8'hBC, 8'h00, 32'd9, 9, 1'b0, 0, 18);         // version beats length
    wait_idle();

    run_random(PhaseBytes);
    write_version(8'h00);
    run_random(PhaseBytes);
    write_version(8'hFF);
    run_random(PhaseBytes);
    mid_ver = 8'($urandom_range(2, 254));
    write_version(mid_ver);
    run_random(PhaseBytes);
    write_version(VersionReset);
    run_random(PhaseBytes);

    wait_idle();
    repeat (10) @(posedge clk_i);

    $display("%0d bytes sent, %0d verdicts checked: ok %0d, invalid %0d, short %0d, crc %0d",
             bytes_taken, verdicts_seen, status_tally[ST_OK], status_tally[ST_INVALID],
             status_tally[ST_SHORT], status_tally[ST_CRC]);
    $display("expected version swept over 01, 00, FF, %02h, 01; %0d errors",
             mid_ver, err_count);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
